// File: src/ift_pkg.sv
package ift_pkg;

    // Widths of the item fields.
    localparam int CHAR_W = 21;
    localparam int CAUSE_W = 2;
    localparam int MAX_TOKEN_W = 16;

    // Defaults for the top-level parameters.
    localparam int LENGTH_BITS_DEF = 16;
    localparam int QUEUE_DEPTH_DEF = 4;

    // Configuration port layout.
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic REG_IDX_MAX_TOKEN = 1'b0;
    localparam logic [MAX_TOKEN_W-1:0] MAX_TOKEN_RESET = 16'd255;

    // Character codes that steer the tokenizer.
    localparam logic [CHAR_W-1:0] CH_COMMA = 21'h00002C;
    localparam logic [CHAR_W-1:0] CH_QUOTE = 21'h000022;
    localparam logic [CHAR_W-1:0] CH_CR    = 21'h00000D;
    localparam logic [CHAR_W-1:0] CH_LF    = 21'h00000A;
    localparam logic [CHAR_W-1:0] CH_TAB   = 21'h000009;
    localparam logic [CHAR_W-1:0] CH_SPACE = 21'h000020;

    // Tokenizer phase.
    typedef enum logic [1:0] {
        PH_LEAD     = 2'd0,
        PH_FIELD    = 2'd1,
        PH_TRAIL    = 2'd2,
        PH_AFTER_CR = 2'd3
    } phase_t;

    // Reason carried by an end marker.
    typedef enum logic [CAUSE_W-1:0] {
        CAUSE_DELIM = 2'd0,
        CAUSE_END   = 2'd1,
        CAUSE_LIMIT = 2'd2,
        CAUSE_QUOTE = 2'd3
    } cause_t;

    // One result item.
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              field_end;
        cause_t            cause;
    } result_t;

    // All results caused by one input item.
    typedef struct packed {
        logic [1:0] cnt;
        result_t    r0;
        result_t    r1;
    } entry_t;

endpackage

// File: src/input_field_tokenizer_top.sv
// Input field tokenizer.
// Input channel: one character item per push (in_char, at_end, text_mode);
// an item is taken when push is high and full is low.
// Result channel: out_char, field_end and end_cause are valid while empty is
// low; pop takes the oldest item. Each input item makes zero, one or two
// result items: field characters and an end marker that closes each field.
// With the result side idle, the first result of an item passes through the
// queue and the output entry register before it reaches the result ports.
// Throughput: one input item per cycle while full is low; the result side
// moves one item per cycle while pop is held, so items that make two results
// drain at half rate. The front end keeps the tokenizer state and settles
// each character combinationally; a queue of QUEUE_DEPTH entries and an
// output register decouple it from the result side. When the receiver stalls
// the queue fills and full rises; input is held off until pop frees space.
// Register at byte address 0: max_token_chars, written over the APB port.
// Reset clears the tokenizer to skipping leading blanks, empties the queue
// and sets max_token_chars to 255.
module input_field_tokenizer_top
    import ift_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    // Input channel.
    input  logic               push,
    output logic               full,
    input  logic [CHAR_W-1:0]  in_char,
    input  logic               at_end,
    input  logic               text_mode,
    // Result channel.
    input  logic               pop,
    output logic               empty,
    output logic [CHAR_W-1:0]  out_char,
    output logic               field_end,
    output logic [CAUSE_W-1:0] end_cause,
    // Configuration port.
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready
);

    logic [MAX_TOKEN_W-1:0] max_token_reg, max_token_next;
    logic                   cfg_wr;
    logic                   q_push, q_pop, q_full, q_empty;
    entry_t                 q_wdata, q_rdata;

    // Configuration register.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        max_token_next = max_token_reg;
        if (cfg_wr && paddr[2] == REG_IDX_MAX_TOKEN)
            max_token_next = pwdata[MAX_TOKEN_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_token_reg <= MAX_TOKEN_RESET;
        else
            max_token_reg <= max_token_next;
    end

    assign prdata = (paddr[2] == REG_IDX_MAX_TOKEN) ? DATA_W'(max_token_reg) : '0;

    // Front end: tokenizer state and classification.
    ift_front #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .in_char         (in_char),
        .at_end          (at_end),
        .text_mode       (text_mode),
        .max_token_chars (max_token_reg),
        .q_full          (q_full),
        .q_push          (q_push),
        .q_entry         (q_wdata)
    );

    // Queue of result entries.
    ift_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wdata),
        .rd_en   (q_pop),
        .rd_data (q_rdata),
        .full    (q_full),
        .empty   (q_empty)
    );

    // Back end: unpacks entries into result items.
    ift_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_data    (q_rdata),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .pop       (pop),
        .empty     (empty),
        .out_char  (out_char),
        .field_end (field_end),
        .end_cause (end_cause)
    );

    assign full = q_full;

endmodule

// File: src/ift_front.sv
module ift_front
    import ift_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  logic [CHAR_W-1:0]      in_char,
    input  logic                   at_end,
    input  logic                   text_mode,
    input  logic [MAX_TOKEN_W-1:0] max_token_chars,
    input  logic                   q_full,
    output logic                   q_push,
    output entry_t                 q_entry
);

    localparam int CW = (LENGTH_BITS > MAX_TOKEN_W) ? LENGTH_BITS : MAX_TOKEN_W;

    phase_t                 phase_reg, phase_next;
    logic                   inq_reg, inq_next;
    logic [LENGTH_BITS-1:0] len_reg, len_next;
    logic                   mode_reg, mode_next;

    logic                   accept;
    logic                   is_comma, is_quote, is_cr, is_lf, is_blank;
    logic                   start;
    logic                   eff_inq, eff_mode, save;
    logic [LENGTH_BITS-1:0] eff_len, len_inc, limit;
    logic [MAX_TOKEN_W-1:0] lim_raw;
    logic [CW-1:0]          lim_w, cap_w;
    entry_t                 ent;

    assign accept = push && !q_full;

    // Character classes.
    assign is_comma = (in_char == CH_COMMA);
    assign is_quote = (in_char == CH_QUOTE);
    assign is_cr    = (in_char == CH_CR);
    assign is_lf    = (in_char == CH_LF);
    assign is_blank = (in_char == CH_SPACE) || (in_char == CH_TAB);

    // Effective length limit: zero acts as one, saturated to the counter range.
    always_comb
    begin
        lim_raw = (max_token_chars == '0) ? MAX_TOKEN_W'(1) : max_token_chars;
        lim_w   = CW'(lim_raw);
        cap_w   = CW'({LENGTH_BITS{1'b1}});
        limit   = (lim_w > cap_w) ? cap_w[LENGTH_BITS-1:0] : lim_w[LENGTH_BITS-1:0];
    end

    // Next state and the results of one item.
    always_comb
    begin
        phase_next = phase_reg;
        inq_next   = inq_reg;
        len_next   = len_reg;
        mode_next  = mode_reg;
        ent        = '0;
        start      = 1'b0;
        save       = 1'b0;
        len_inc    = '0;

        unique case (phase_reg)
            PH_FIELD:
            begin
                if (at_end)
                begin
                    ent.cnt          = 2'd1;
                    ent.r0.field_end = 1'b1;
                    ent.r0.cause     = CAUSE_END;
                    phase_next       = PH_LEAD;
                end
            end
            PH_TRAIL:
            begin
                if (at_end || is_comma || is_lf)
                    phase_next = PH_LEAD;
                else if (is_cr)
                    phase_next = PH_AFTER_CR;
                else if (!is_blank)
                    start = 1'b1;
            end
            PH_AFTER_CR:
            begin
                // A blank after a CR goes back to skipping leading blanks.
                if (at_end || is_lf || is_blank)
                    phase_next = PH_LEAD;
                else
                    start = 1'b1;
            end
            default:
            begin
                phase_next = PH_LEAD;
                if (at_end)
                begin
                    ent.cnt          = 2'd1;
                    ent.r0.field_end = 1'b1;
                    ent.r0.cause     = CAUSE_END;
                end
                else if (!is_blank)
                    start = 1'b1;
            end
        endcase

        // A new field starts from cleared field state and the sampled mode.
        eff_inq  = start ? 1'b0 : inq_reg;
        eff_len  = start ? '0 : len_reg;
        eff_mode = start ? text_mode : mode_reg;
        if (start)
        begin
            phase_next = PH_FIELD;
            inq_next   = 1'b0;
            len_next   = '0;
            mode_next  = text_mode;
        end

        // Character handling inside a field.
        if (start || (phase_reg == PH_FIELD && !at_end))
        begin
            if (is_lf)
            begin
                ent.cnt          = 2'd1;
                ent.r0.field_end = 1'b1;
                ent.r0.cause     = CAUSE_DELIM;
                phase_next       = PH_LEAD;
            end
            else if (is_cr)
            begin
                ent.cnt          = 2'd1;
                ent.r0.field_end = 1'b1;
                ent.r0.cause     = CAUSE_DELIM;
                phase_next       = PH_AFTER_CR;
            end
            else if (is_quote)
            begin
                if (!eff_inq)
                begin
                    if (eff_len == '0)
                        inq_next = 1'b1;
                    else
                        save = 1'b1;
                end
                else
                begin
                    inq_next = 1'b0;
                    if (eff_mode)
                    begin
                        ent.cnt          = 2'd1;
                        ent.r0.field_end = 1'b1;
                        ent.r0.cause     = CAUSE_QUOTE;
                        phase_next       = PH_TRAIL;
                    end
                end
            end
            else if (is_comma)
            begin
                if (!eff_inq)
                begin
                    ent.cnt          = 2'd1;
                    ent.r0.field_end = 1'b1;
                    ent.r0.cause     = CAUSE_DELIM;
                    phase_next       = PH_LEAD;
                end
                else
                    save = 1'b1;
            end
            else if (is_blank)
            begin
                if (!eff_inq && !eff_mode)
                begin
                    ent.cnt          = 2'd1;
                    ent.r0.field_end = 1'b1;
                    ent.r0.cause     = CAUSE_DELIM;
                    phase_next       = PH_TRAIL;
                end
                else
                    save = 1'b1;
            end
            else
                save = 1'b1;

            // Store the character and cut the field at the limit.
            if (save)
            begin
                len_inc   = eff_len + 1'b1;
                len_next  = len_inc;
                ent.cnt   = 2'd1;
                ent.r0.ch = in_char;
                if (len_inc >= limit)
                begin
                    ent.cnt          = 2'd2;
                    ent.r1.field_end = 1'b1;
                    ent.r1.cause     = CAUSE_LIMIT;
                    phase_next       = PH_TRAIL;
                end
            end
        end
    end

    // Tokenizer state register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LEAD;
            inq_reg   <= 1'b0;
            len_reg   <= '0;
            mode_reg  <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            inq_reg   <= inq_next;
            len_reg   <= len_next;
            mode_reg  <= mode_next;
        end
    end

    // Only items that cause results enter the queue.
    assign q_push  = accept && (ent.cnt != 2'd0);
    assign q_entry = ent;

endmodule

// File: src/ift_queue.sv
module ift_queue
    import ift_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   wr_en,
    input  entry_t wr_data,
    input  logic   rd_en,
    output entry_t rd_data,
    output logic   full,
    output logic   empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t             entries_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_wr, do_rd;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign do_wr = wr_en && !full;
    assign do_rd = rd_en && !empty;
    assign rd_data = entries_reg[rd_ptr_reg];

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_wr)
            entries_reg[wr_ptr_reg] <= wr_data;
    end

    // Occupancy never goes past the depth.
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CNT_W'(DEPTH))
        else $error("queue occupancy above depth");

    // A write into a full queue would drop an item's results.
    assert property (@(posedge clk) disable iff (!rst_n) wr_en |-> !full)
        else $error("write into full queue");

endmodule

// File: src/ift_back.sv
module ift_back
    import ift_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  entry_t            q_data,
    input  logic              q_empty,
    output logic              q_pop,
    input  logic              pop,
    output logic              empty,
    output logic [CHAR_W-1:0] out_char,
    output logic              field_end,
    output logic [CAUSE_W-1:0] end_cause
);

    entry_t  cur_reg;
    logic    valid_reg, valid_next;
    logic    sel_reg, sel_next;
    logic    taken, last, reload;
    result_t res;

    assign empty = !valid_reg;
    assign taken = pop && valid_reg;
    assign last  = sel_reg || (cur_reg.cnt == 2'd1);
    assign reload = !valid_reg || (taken && last);
    assign q_pop = reload && !q_empty;

    // Step through the current entry, then fetch the next one.
    always_comb
    begin
        valid_next = valid_reg;
        sel_next   = sel_reg;
        if (reload)
        begin
            valid_next = !q_empty;
            sel_next   = 1'b0;
        end
        else if (taken)
            sel_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            sel_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            sel_reg   <= sel_next;
        end
    end

    // Output entry register.
    always_ff @(posedge clk)
    begin
        if (q_pop)
            cur_reg <= q_data;
    end

    // Present the selected item of the entry.
    assign res       = sel_reg ? cur_reg.r1 : cur_reg.r0;
    assign out_char  = res.ch;
    assign field_end = res.field_end;
    assign end_cause = res.cause;

    // A held entry always carries at least one item.
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (cur_reg.cnt == 2'd1 || cur_reg.cnt == 2'd2))
        else $error("held entry without items");

    // The second item is only shown for entries that have two.
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && sel_reg) |-> (cur_reg.cnt == 2'd2))
        else $error("second item selected in single-item entry");

endmodule
